### sv/sns_pkg.sv
// Shared constants and types for the small array sorting network.
`timescale 1ns / 1ps

package sns_pkg;

  // Element slots carried by every beat.
  localparam int SLOTS = 8;

  // Width of the count field.
  localparam int CNT_W = 4;

  typedef logic [CNT_W-1:0] count_t;

endpackage : sns_pkg

### sv/small_array_sorting_network.sv
// Top level: pipelined odd-even transposition sorter for up to eight elements.
// Pipeline: one register stage per transposition round between an accepted
//   input beat and its result beat.
// Throughput: one beat per cycle while out_stall is low; each stage holds one
//   beat and refills in the cycle its beat moves on, so out_stall backs up stage by stage.
// Reset: synchronous, active low; clears every stage's valid bit, data is kept.
`timescale 1ns / 1ps

module small_array_sorting_network #(
  parameter int DATA_WIDTH = 32,
  parameter int CAPACITY   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sns_pkg::CNT_W-1:0]     in_count,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_0,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_1,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_2,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_3,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_4,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_5,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_6,
  input  logic signed [DATA_WIDTH-1:0]  in_elem_7,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_0,
  output logic signed [DATA_WIDTH-1:0]  out_1,
  output logic signed [DATA_WIDTH-1:0]  out_2,
  output logic signed [DATA_WIDTH-1:0]  out_3,
  output logic signed [DATA_WIDTH-1:0]  out_4,
  output logic signed [DATA_WIDTH-1:0]  out_5,
  output logic signed [DATA_WIDTH-1:0]  out_6,
  output logic signed [DATA_WIDTH-1:0]  out_7
);

  import sns_pkg::*;

  // Links between stages; index 0 is the input side, CAPACITY the output.
  logic                             valid [0:CAPACITY];
  logic                             ready [0:CAPACITY];
  count_t                           count [0:CAPACITY];
  logic [SLOTS-1:0][DATA_WIDTH-1:0] elems [0:CAPACITY];

  // Counts above capacity sort the whole capacity. Slots past CAPACITY are
  // never touched since the saturated count keeps every pair beyond it idle.
  assign count[0] = (in_count > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : in_count;

  assign elems[0][0] = in_elem_0;
  assign elems[0][1] = in_elem_1;
  assign elems[0][2] = in_elem_2;
  assign elems[0][3] = in_elem_3;
  assign elems[0][4] = in_elem_4;
  assign elems[0][5] = in_elem_5;
  assign elems[0][6] = in_elem_6;
  assign elems[0][7] = in_elem_7;

  assign valid[0] = in_valid;
  assign in_stall = !ready[0];

  // m rounds of odd-even transposition sort m elements, so CAPACITY rounds
  // cover every legal count. Rounds alternate even and odd pairs.
  for (genvar s = 0; s < CAPACITY; s++) begin : g_round
    sns_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .PARITY     (s % 2)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid[s]),
      .up_ready (ready[s]),
      .up_count (count[s]),
      .up_elems (elems[s]),
      .dn_valid (valid[s+1]),
      .dn_ready (ready[s+1]),
      .dn_count (count[s+1]),
      .dn_elems (elems[s+1])
    );
  end

  // Result beat comes straight off the last stage register.
  assign ready[CAPACITY] = !out_stall;
  assign out_valid       = valid[CAPACITY];

  assign out_0 = elems[CAPACITY][0];
  assign out_1 = elems[CAPACITY][1];
  assign out_2 = elems[CAPACITY][2];
  assign out_3 = elems[CAPACITY][3];
  assign out_4 = elems[CAPACITY][4];
  assign out_5 = elems[CAPACITY][5];
  assign out_6 = elems[CAPACITY][6];
  assign out_7 = elems[CAPACITY][7];

endmodule : small_array_sorting_network

### sv/sns_stage.sv
// One odd-even transposition round of the sorter, with its pipeline register.
`timescale 1ns / 1ps

module sns_stage #(
  parameter int DATA_WIDTH = 32,
  parameter int PARITY     = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  sns_pkg::count_t                               up_count,
  input  logic [sns_pkg::SLOTS-1:0][DATA_WIDTH-1:0]     up_elems,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output sns_pkg::count_t                               dn_count,
  output logic [sns_pkg::SLOTS-1:0][DATA_WIDTH-1:0]     dn_elems
);

  import sns_pkg::*;

  logic                                 valid_r;
  count_t                               count_r;
  logic [SLOTS-1:0][DATA_WIDTH-1:0]     elems_r;
  logic [SLOTS-1:0][DATA_WIDTH-1:0]     elems_nxt;
  logic                                 load;

  assign load     = !valid_r || dn_ready;
  assign up_ready = load;

  // Pairs (j, j+1) of this round's parity; only pairs inside the count swap.
  always_comb begin
    elems_nxt = up_elems;
    for (int j = PARITY; j + 1 < SLOTS; j += 2) begin
      if ((CNT_W'(j + 1) < up_count) &&
          ($signed(up_elems[j]) > $signed(up_elems[j+1]))) begin
        elems_nxt[j]   = up_elems[j+1];
        elems_nxt[j+1] = up_elems[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      count_r <= up_count;
      elems_r <= elems_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_count = count_r;
  assign dn_elems = elems_r;

endmodule : sns_stage

### tb/tb_small_array_sorting_network.sv
// Self-checking testbench for the small array sorting network.
`timescale 1ns / 1ps

module tb_small_array_sorting_network;
  import sns_pkg::*;

  localparam int DW       = 32;
  localparam int CAPACITY = 8;
  localparam int LATENCY  = CAPACITY;

  localparam logic [DW-1:0] MIN_WORD = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_WORD = {1'b0, {(DW-1){1'b1}}};

  typedef logic [DW-1:0] word_t;
  // One beat of elements; index i is element i.
  typedef logic [SLOTS-1:0][DW-1:0] row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  count_t in_count = '0;
  logic signed [DW-1:0] in_elem_0 = '0, in_elem_1 = '0, in_elem_2 = '0, in_elem_3 = '0;
  logic signed [DW-1:0] in_elem_4 = '0, in_elem_5 = '0, in_elem_6 = '0, in_elem_7 = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic signed [DW-1:0] out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
  row_t   out_row;

  // Sorted rows still owed by the block, oldest first.
  row_t sorted_q[$];
  int   mismatch_count = 0;

  // Idle knobs: sender gaps, receiver stalls, and a one-shot long hold-off.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_off_req = 0;

  assign out_row = {out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};

  small_array_sorting_network #(
    .DATA_WIDTH(DW),
    .CAPACITY  (CAPACITY)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_count (in_count),
    .in_elem_0(in_elem_0),
    .in_elem_1(in_elem_1),
    .in_elem_2(in_elem_2),
    .in_elem_3(in_elem_3),
    .in_elem_4(in_elem_4),
    .in_elem_5(in_elem_5),
    .in_elem_6(in_elem_6),
    .in_elem_7(in_elem_7),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_0    (out_0),
    .out_1    (out_1),
    .out_2    (out_2),
    .out_3    (out_3),
    .out_4    (out_4),
    .out_5    (out_5),
    .out_6    (out_6),
    .out_7    (out_7)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected output: the leading count elements in ascending signed order,
  // everything above passed through. Counts past capacity clamp to capacity;
  // counts 0 and 1 leave the beat untouched.
  function automatic row_t sort_prefix(count_t cnt, row_t vals);
    row_t  r;
    word_t t;
    int    m;
    r = vals;
    m = (cnt > CAPACITY) ? CAPACITY : int'(cnt);
    for (int i = 0; i + 1 < m; i++) begin
      for (int j = 0; j + 1 < m - i; j++) begin
        if ($signed(r[j]) > $signed(r[j+1])) begin
          t      = r[j];
          r[j]   = r[j+1];
          r[j+1] = t;
        end
      end
    end
    return r;
  endfunction

  // Element draw: full range, a narrow band around zero (forces duplicates),
  // or one of the boundary values.
  function automatic word_t rand_word();
    case ($urandom_range(0, 3))
      0, 1: return word_t'($urandom);
      2: return word_t'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0: return MIN_WORD;
          1: return MAX_WORD;
          2: return '1;
          3: return '0;
          default: return word_t'(1);
        endcase
      end
    endcase
  endfunction

  // Drive one input beat and hold it until accepted. Called at a rising edge;
  // in_valid stays high across back-to-back beats (no gap drawn).
  task automatic send_sort(input count_t cnt, input row_t vals);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_count  <= cnt;
    in_elem_0 <= vals[0];
    in_elem_1 <= vals[1];
    in_elem_2 <= vals[2];
    in_elem_3 <= vals[3];
    in_elem_4 <= vals[4];
    in_elem_5 <= vals[5];
    in_elem_6 <= vals[6];
    in_elem_7 <= vals[7];
    do @(posedge clk); while (in_stall !== 1'b0);
    sorted_q.push_back(sort_prefix(cnt, vals));
  endtask

  task automatic check_result();
    row_t want;
    if (sorted_q.size() == 0) begin
      $error("result beat with no input pending");
      mismatch_count++;
    end else begin
      want = sorted_q.pop_front();
      for (int i = 0; i < SLOTS; i++) begin
        if (out_row[i] !== want[i]) begin
          $error("out_%0d: expected %0d, actual %0d", i, $signed(want[i]),
                 $signed(out_row[i]));
          mismatch_count++;
        end
      end
    end
  endtask

  // Result side: draw a stall per beat (or take the long hold-off when asked),
  // then wait for the next accepted beat and check it.
  initial begin : result_sink
    int hold;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        hold = hold_off_req;
        hold_off_req = 0;
      end else begin
        hold = recv_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result();
    end
  end

  // Counts 0 and 1: nothing moves, even with descending data.
  task automatic test_pass_through();
    row_t r;
    for (int i = 0; i < SLOTS; i++) r[i] = word_t'(100 - 10 * i);
    send_sort(count_t'(0), r);
    send_sort(count_t'(1), r);
  endtask

  // Every sortable count with reversed data, signs mixed; tail must pass.
  task automatic test_every_count();
    row_t r;
    for (int c = 2; c <= CAPACITY; c++) begin
      for (int i = 0; i < SLOTS; i++) r[i] = word_t'(3000 - 1000 * i);
      if (c == CAPACITY) begin
        r[0] = MAX_WORD;
        r[7] = MIN_WORD;
      end
      send_sort(count_t'(c), r);
    end
  endtask

  // Counts above capacity clamp to a full sort.
  task automatic test_count_saturation();
    row_t r;
    for (int c = CAPACITY + 1; c < (1 << CNT_W); c++) begin
      for (int i = 0; i < SLOTS; i++) r[i] = word_t'($urandom);
      send_sort(count_t'(c), r);
    end
  endtask

  // Boundary values, duplicates, all-equal and alternating extremes.
  task automatic test_extreme_values();
    row_t r;
    r = {MIN_WORD, word_t'(0), MAX_WORD, word_t'(1),
         word_t'(0), word_t'('1), MIN_WORD, MAX_WORD};
    send_sort(count_t'(CAPACITY), r);
    r = {SLOTS{word_t'('1)}};
    send_sort(count_t'(CAPACITY), r);
    for (int i = 0; i < SLOTS; i++) r[i] = i[0] ? MIN_WORD : MAX_WORD;
    send_sort(count_t'(CAPACITY), r);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // beats back to back, so the pipe fills and in_stall rises.
  task automatic test_backpressure();
    row_t r;
    send_idle    = 1'b0;
    hold_off_req = 80;
    for (int n = 0; n < 40; n++) begin
      for (int i = 0; i < SLOTS; i++) r[i] = rand_word();
      send_sort(count_t'($urandom_range(0, 15)), r);
    end
  endtask

  // Random arrays in blocks; each block picks its own mix of sender gaps and
  // receiver stalls so all four combinations appear, including no idling.
  task automatic test_random_arrays();
    row_t   r;
    count_t cnt;
    for (int blk = 0; blk < 10; blk++) begin
      send_idle = (blk % 2) != 0;
      recv_idle = ((blk / 2) % 2) != 0;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) == 0) cnt = count_t'($urandom_range(0, 15));
        else cnt = count_t'($urandom_range(2, CAPACITY));
        for (int i = 0; i < SLOTS; i++) r[i] = rand_word();
        send_sort(cnt, r);
      end
    end
  endtask

  initial begin : main
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_every_count();
    test_count_saturation();
    test_extreme_values();
    test_backpressure();
    test_random_arrays();
    in_valid <= 1'b0;

    // Drain: wait for every beat owed, then a pipe's worth for strays.
    waited = 0;
    while (sorted_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (sorted_q.size() != 0) begin
      $error("%0d expected result beats never arrived", sorted_q.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
